// ===== hdl/vlbs_pkg.sv =====
// Package: shared types and constants of the virtual link BAG and frame sizer.
`timescale 1ns / 1ps
`default_nettype none
package vlbs_pkg;

    localparam int ONE_FRAME_PAYLOAD = 1471;
    localparam int FRAME_OVERHEAD    = 47;
    localparam int MIN_FRAME_LEN     = 64;
    localparam int TOP_GAP           = 128;
    localparam int GAP_STEPS         = 8;
    localparam int RECIP_SHIFT       = 26;
    localparam int CEIL_RECIP        = (1 << RECIP_SHIFT) / ONE_FRAME_PAYLOAD;
    localparam int DIV_STEPS         = 17;

    typedef struct packed {
        logic [15:0] msg_bytes;
        logic [15:0] period_ms;
        logic [15:0] latency_limit;
        logic [15:0] jitter_limit;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic [15:0] frame_count;
        logic [10:0] max_frame_len;
        logic [7:0]  gap_ms;
    } t_out;

    typedef struct packed {
        logic load;
        logic mul;
        logic minq;
        logic step;
        logic fin;
        logic div;
    } t_cmd;

    typedef struct packed {
        logic last_step;
        logic div_done;
    } t_sts;

endpackage
`default_nettype wire

// ===== hdl/virtual_link_bag_and_frame_sizer.sv =====
// Top level: virtual link BAG and frame sizer with registered result.
//
// Input channel: i_in_valid / o_in_stall carry one flow description (message
// size, period, latency limit, jitter limit) per transaction in i_in.
// Output channel: o_out_valid / i_out_stall carry one result per input
// transaction in o_out: ok, frame count, maximum frame length and BAG.
// Every input transaction yields exactly one output transaction.
// Steps in order: capture, a reciprocal multiply and correction for the least
// frame count, eight BAG search steps from 128 down to 1, and a 17-step
// restoring divider for the frame length.
// o_in_stall is high while an item is in work. A finished result waits in
// its final step until the output register is free; the block accepts the
// next item as soon as the result moves into the output register, even if
// the receiver keeps stalling. A stalled output holds its payload.
// Reset (synchronous, active low) returns the controller to idle and clears
// the output valid; no memories need clearing.
`timescale 1ns / 1ps
`default_nettype none
module virtual_link_bag_and_frame_sizer (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire vlbs_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output vlbs_pkg::t_out     o_out
);

    vlbs_pkg::t_cmd cmd;
    vlbs_pkg::t_sts sts;
    vlbs_pkg::t_out res;
    logic           busy;
    logic           out_load;
    logic           out_free;
    logic           r_out_valid;
    vlbs_pkg::t_out r_out;

    assign out_free = !r_out_valid || !i_out_stall;

    vlbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_out_load (out_load)
    );

    vlbs_dp u_dp (
        .i_clk (i_clk),
        .i_cmd (cmd),
        .i_in  (i_in),
        .o_sts (sts),
        .o_res (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.ok) |->
        (o_out.frame_count == 16'd0 && o_out.max_frame_len == 11'd0 && o_out.gap_ms == 8'd0))
        else $error("failed result carries nonzero fields");

    a_gap_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.ok) |-> ($onehot(o_out.gap_ms) && o_out.frame_count != 16'd0))
        else $error("sized result without single-bit gap or with zero frames");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while previous transaction still in work");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result loaded over a stalled output");

endmodule
`default_nettype wire

// ===== hdl/vlbs_ctrl.sv =====
// Controller: sequences capture, search, divide and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module vlbs_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_out_free,
    input  wire vlbs_pkg::t_sts i_sts,
    output vlbs_pkg::t_cmd      o_cmd,
    output logic                o_busy,
    output logic                o_out_load
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_MINQ   = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_MINQ;
            end
            S_MINQ: begin
                o_cmd.minq = 1'b1;
                n_state    = S_SEARCH;
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_step) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div = 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== hdl/vlbs_dp.sv =====
// Datapath: operand registers, gap search, frame count bound and length divider.
`timescale 1ns / 1ps
`default_nettype none
module vlbs_dp (
    input  wire                 i_clk,
    input  wire vlbs_pkg::t_cmd i_cmd,
    input  wire vlbs_pkg::t_in  i_in,
    output vlbs_pkg::t_sts      o_sts,
    output vlbs_pkg::t_out      o_res
);

    function automatic logic many_jit_ok(
        input logic [15:0]        n,
        input logic [2:0]         sh,
        input logic signed [17:0] d,
        input logic [15:0]        sig,
        input logic               sig_pos
    );
        logic signed [26:0] nk;
        logic signed [26:0] n2k;
        logic signed [26:0] dd;
        logic signed [26:0] sd;
        nk  = $signed({11'd0, n}) <<< sh;
        n2k = (($signed({11'd0, n}) <<< 1) - 27'sd1) <<< sh;
        dd  = $signed({{9{d[17]}}, d});
        sd  = dd + $signed({11'd0, sig});
        return !sig_pos || (nk <= dd) || (n2k <= sd);
    endfunction

    logic [15:0] r_size;
    logic [15:0] r_period;
    logic [15:0] r_lat;
    logic [15:0] r_jit;
    logic [32:0] r_prod;
    logic [5:0]  r_min_n;
    logic [15:0] r_max_n;
    logic [2:0]  r_k_idx;
    logic        r_found;
    logic        r_fail;
    logic [15:0] r_n;
    logic [7:0]  r_gap;
    logic [15:0] r_rem;
    logic [16:0] r_quo;
    logic [4:0]  r_dcnt;

    logic               one_frame;
    logic [16:0]        x_ceil;
    logic [6:0]         q0;
    logic [6:0]         q1;
    logic [16:0]        q1_mul;
    logic [5:0]         min_n_c;
    logic [15:0]        max_n_c;
    logic signed [17:0] d;
    logic [15:0]        sig;
    logic               sig_pos;
    logic [7:0]         k;
    logic signed [19:0] d20;
    logic signed [19:0] k20;
    logic signed [19:0] l20;
    logic               of_pass;
    logic [15:0]        cand_p;
    logic [16:0]        cs;
    logic [15:0]        cand;
    logic               in_b;
    logic               mj;
    logic               fb_ok;
    logic [15:0]        n_div;
    logic [16:0]        trial;
    logic [16:0]        diff;
    logic               ge;
    logic [10:0]        len1;
    logic               ok;

    assign one_frame = (r_size <= 16'(vlbs_pkg::ONE_FRAME_PAYLOAD));
    assign x_ceil    = {1'b0, r_size} + 17'(vlbs_pkg::ONE_FRAME_PAYLOAD - 1);
    assign q0        = r_prod[vlbs_pkg::RECIP_SHIFT +: 7];
    assign q1        = q0 + 7'd1;
    assign q1_mul    = 17'(q1 * vlbs_pkg::ONE_FRAME_PAYLOAD);
    assign min_n_c   = (q1_mul <= x_ceil) ? q1[5:0] : q0[5:0];
    assign max_n_c   = ((r_lat != 16'd0) && (r_lat < r_period)) ? r_lat : r_period;

    assign d       = $signed({2'b00, r_period}) - $signed({2'b00, r_jit});
    assign sig     = r_lat - 16'd1;
    assign sig_pos = (r_lat > 16'd1);
    assign k       = 8'd1 << r_k_idx;

    assign d20     = $signed({{2{d[17]}}, d});
    assign k20     = $signed({12'd0, k});
    assign l20     = $signed({4'd0, r_lat});
    assign of_pass = ({8'd0, k} <= r_period) &&
                     ((r_lat == 16'd0) || (k20 <= d20) || ((k20 - d20) <= (l20 - 20'sd1)));

    assign cand_p = r_period >> r_k_idx;
    assign cs     = {1'b0, sig >> r_k_idx} + 17'd1;
    assign cand   = (sig_pos && (cs < {1'b0, cand_p})) ? cs[15:0] : cand_p;
    assign in_b   = ({10'd0, r_min_n} <= cand) && (cand <= r_max_n);
    assign mj     = many_jit_ok(cand, r_k_idx, d, sig, sig_pos);
    assign fb_ok  = many_jit_ok(r_max_n, 3'd0, d, sig, sig_pos);
    assign n_div  = r_found ? r_n : r_max_n;

    assign trial = {r_rem, r_quo[16]};
    assign diff  = trial - {1'b0, r_n};
    assign ge    = (trial >= {1'b0, r_n});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_size   <= i_in.msg_bytes;
            r_period <= i_in.period_ms;
            r_lat    <= i_in.latency_limit;
            r_jit    <= i_in.jitter_limit;
            r_k_idx  <= 3'(vlbs_pkg::GAP_STEPS - 1);
            r_found  <= 1'b0;
            r_fail   <= 1'b0;
            r_n      <= 16'd0;
            r_gap    <= 8'd0;
        end
        if (i_cmd.mul) begin
            r_prod <= {16'd0, x_ceil} * 33'(vlbs_pkg::CEIL_RECIP);
        end
        if (i_cmd.minq) begin
            r_min_n <= min_n_c;
            r_max_n <= max_n_c;
            if (!one_frame && ((r_lat == 16'd1) || ({10'd0, min_n_c} > max_n_c))) begin
                r_fail <= 1'b1;
            end
        end
        if (i_cmd.step) begin
            r_k_idx <= r_k_idx - 3'd1;
            if (!r_found && !r_fail) begin
                if (one_frame) begin
                    if (of_pass) begin
                        r_found <= 1'b1;
                        r_n     <= 16'd1;
                        r_gap   <= k;
                    end
                end else if (in_b && mj) begin
                    r_found <= 1'b1;
                    r_n     <= cand;
                    r_gap   <= k;
                end else if (cand > r_max_n) begin
                    r_found <= 1'b1;
                    r_n     <= r_max_n;
                    r_gap   <= k;
                end
            end
        end
        if (i_cmd.fin) begin
            if (!one_frame && !r_found && !r_fail) begin
                if (fb_ok) begin
                    r_found <= 1'b1;
                    r_n     <= r_max_n;
                    r_gap   <= 8'd1;
                end else begin
                    r_fail <= 1'b1;
                end
            end
            r_rem  <= 16'd0;
            r_quo  <= {1'b0, r_size} + {1'b0, n_div} - 17'd1;
            r_dcnt <= 5'd0;
        end
        if (i_cmd.div) begin
            r_rem  <= ge ? diff[15:0] : trial[15:0];
            r_quo  <= {r_quo[15:0], ge};
            r_dcnt <= r_dcnt + 5'd1;
        end
    end

    assign o_sts.last_step = (r_k_idx == 3'd0);
    assign o_sts.div_done  = (r_dcnt == 5'(vlbs_pkg::DIV_STEPS));

    assign ok   = r_found && !r_fail;
    assign len1 = (r_size[10:0] + 11'(vlbs_pkg::FRAME_OVERHEAD) < 11'(vlbs_pkg::MIN_FRAME_LEN)) ?
                  11'(vlbs_pkg::MIN_FRAME_LEN) : r_size[10:0] + 11'(vlbs_pkg::FRAME_OVERHEAD);

    always_comb begin
        o_res = '0;
        if (ok) begin
            o_res.ok            = 1'b1;
            o_res.frame_count   = r_n;
            o_res.gap_ms        = r_gap;
            o_res.max_frame_len = one_frame ? len1 :
                                  r_quo[10:0] + 11'(vlbs_pkg::FRAME_OVERHEAD);
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_virtual_link_bag_and_frame_sizer.sv =====
// Testbench: checks the virtual link BAG and frame sizer against a predictor, with random stalls.
`timescale 1ns / 1ps
module tb_virtual_link_bag_and_frame_sizer;

    localparam int FLOW_ROW_COUNT = 20;
    localparam int RANDOM_FLOWS   = 2000;
    localparam int QUIET_FLOWS    = 200;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 1000000;

    localparam vlbs_pkg::t_out LINK_FAIL = '0;

    typedef struct packed {
        vlbs_pkg::t_in  flow;
        logic           typed;
        vlbs_pkg::t_out want;
    } t_flow_row;

    localparam t_flow_row FLOW_ROWS [0:FLOW_ROW_COUNT-1] = '{
        {16'd0,     16'd65535, 16'd0,     16'd0,     1'b1, 1'b1, 16'd1, 11'd64,   8'd128},
        {16'd1471,  16'd128,   16'd0,     16'd0,     1'b1, 1'b1, 16'd1, 11'd1518, 8'd128},
        {16'd16,    16'd1,     16'd0,     16'd0,     1'b1, 1'b1, 16'd1, 11'd64,   8'd1},
        {16'd0,     16'd0,     16'd0,     16'd0,     1'b1, LINK_FAIL},
        {16'd100,   16'd0,     16'd0,     16'd0,     1'b1, LINK_FAIL},
        {16'd1472,  16'd0,     16'd0,     16'd0,     1'b1, LINK_FAIL},
        {16'd10,    16'd5,     16'd1,     16'd65535, 1'b1, LINK_FAIL},
        {16'd2000,  16'd100,   16'd1,     16'd0,     1'b1, LINK_FAIL},
        {16'd65535, 16'd1,     16'd0,     16'd0,     1'b1, LINK_FAIL},
        {16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b0, LINK_FAIL},
        {16'd65535, 16'd65535, 16'd0,     16'd0,     1'b0, LINK_FAIL},
        {16'd1472,  16'd2,     16'd0,     16'd0,     1'b0, LINK_FAIL},
        {16'd3000,  16'd3,     16'd3,     16'd65535, 1'b0, LINK_FAIL},
        {16'd5000,  16'd1000,  16'd50,    16'd990,   1'b0, LINK_FAIL},
        {16'd40000, 16'd300,   16'd100,   16'd10,    1'b0, LINK_FAIL},
        {16'd1471,  16'd127,   16'd0,     16'd0,     1'b0, LINK_FAIL},
        {16'd1000,  16'd65535, 16'd10,    16'd65535, 1'b0, LINK_FAIL},
        {16'd47,    16'd200,   16'd2,     16'd199,   1'b0, LINK_FAIL},
        {16'd2942,  16'd2,     16'd0,     16'd0,     1'b0, LINK_FAIL},
        {16'd1470,  16'd1,     16'd65535, 16'd0,     1'b0, LINK_FAIL}
    };

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    vlbs_pkg::t_in  i_in        = '0;
    logic           i_out_stall = 1'b0;
    logic           o_in_stall;
    logic           o_out_valid;
    vlbs_pkg::t_out o_out;

    vlbs_pkg::t_out link_q[$];
    int   mismatches  = 0;
    int   flows_taken = 0;
    int   cycle_cnt   = 0;
    int   stall_left  = 0;
    logic long_hold   = 1'b0;
    logic quiet       = 1'b0;

    virtual_link_bag_and_frame_sizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit spread_fits(input longint n, input longint g, input longint per,
                                       input longint sig, input longint jit);
        return sig == 0 || n * g <= per - jit || (2 * n - 1) * g <= sig + per - jit;
    endfunction

    function automatic vlbs_pkg::t_out size_link(input vlbs_pkg::t_in f);
        longint sz, per, lat, jit, len, g, k, min_n, max_n, sig, n, cand;
        vlbs_pkg::t_out r;
        r   = LINK_FAIL;
        sz  = longint'(f.msg_bytes);
        per = longint'(f.period_ms);
        lat = longint'(f.latency_limit);
        jit = longint'(f.jitter_limit);
        if (sz <= vlbs_pkg::ONE_FRAME_PAYLOAD) begin
            len = sz + vlbs_pkg::FRAME_OVERHEAD;
            if (len < vlbs_pkg::MIN_FRAME_LEN) len = vlbs_pkg::MIN_FRAME_LEN;
            g = vlbs_pkg::TOP_GAP;
            while (g > 0 && (g > per ||
                   !(lat == 0 || g <= per - jit || g - (per - jit) <= lat - 1)))
                g = g >> 1;
            if (g != 0) begin
                r.ok            = 1'b1;
                r.frame_count   = 16'd1;
                r.max_frame_len = len[10:0];
                r.gap_ms        = g[7:0];
            end
            return r;
        end
        min_n = (sz + vlbs_pkg::ONE_FRAME_PAYLOAD - 1) / vlbs_pkg::ONE_FRAME_PAYLOAD;
        max_n = per;
        sig   = 0;
        if (lat > 0) begin
            if (lat <= 1) return r;
            sig = lat - 1;
            if (sig + 1 < max_n) max_n = sig + 1;
        end
        if (min_n > max_n) return r;
        n = 0;
        g = 0;
        for (k = vlbs_pkg::TOP_GAP; k >= 1 && g == 0; k = k >> 1) begin
            cand = per / k;
            if (sig > 0 && sig / k + 1 < cand) cand = sig / k + 1;
            if (min_n <= cand && cand <= max_n && spread_fits(cand, k, per, sig, jit)) begin
                n = cand;
                g = k;
            end else if (cand > max_n) begin
                n = max_n;
                g = k;
            end
        end
        if (g == 0) begin
            n = max_n;
            g = 1;
            if (!spread_fits(n, g, per, sig, jit)) return r;
        end
        if (n <= 0) return r;
        len             = (sz + n - 1) / n + vlbs_pkg::FRAME_OVERHEAD;
        r.ok            = 1'b1;
        r.frame_count   = n[15:0];
        r.max_frame_len = len[10:0];
        r.gap_ms        = g[7:0];
        return r;
    endfunction

    function automatic vlbs_pkg::t_in random_flow();
        vlbs_pkg::t_in f;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: f.msg_bytes = 16'($urandom_range(0, vlbs_pkg::ONE_FRAME_PAYLOAD));
            4, 5, 6, 7: f.msg_bytes = 16'($urandom_range(vlbs_pkg::ONE_FRAME_PAYLOAD + 1,
                                                         12000));
            8:          f.msg_bytes = 16'($urandom_range(0, 65535));
            default: begin
                case ($urandom_range(0, 3))
                    0:       f.msg_bytes = 16'(vlbs_pkg::ONE_FRAME_PAYLOAD);
                    1:       f.msg_bytes = 16'(vlbs_pkg::ONE_FRAME_PAYLOAD + 1);
                    2:       f.msg_bytes = 16'hFFFF;
                    default: f.msg_bytes = 16'd0;
                endcase
            end
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: f.period_ms = 16'($urandom_range(1, 300));
            6, 7:             f.period_ms = 16'($urandom_range(1, 2000));
            8:                f.period_ms = 16'($urandom_range(1, 65535));
            default:          f.period_ms = 16'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: f.latency_limit = 16'd0;
            4, 5, 6:    f.latency_limit = 16'($urandom_range(1, 300));
            7:          f.latency_limit = 16'($urandom_range(1, 2));
            8:          f.latency_limit = 16'($urandom_range(0, 65535));
            default:    f.latency_limit = f.period_ms;
        endcase
        case ($urandom_range(0, 8))
            0, 1, 2, 3: f.jitter_limit = 16'($urandom_range(0, f.period_ms));
            4, 5, 6:    f.jitter_limit = 16'($urandom_range(0, 20));
            default:    f.jitter_limit = 16'($urandom_range(0, 65535));
        endcase
        return f;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    task automatic check_link(input vlbs_pkg::t_out got);
        vlbs_pkg::t_out want;
        if (link_q.size() == 0) begin
            report_mismatch("result with no flow pending");
            return;
        end
        want = link_q.pop_front();
        if (got.ok !== want.ok)
            report_mismatch($sformatf("ok got %0d want %0d", got.ok, want.ok));
        if (got.frame_count !== want.frame_count)
            report_mismatch($sformatf("frame_count got %0d want %0d",
                                      got.frame_count, want.frame_count));
        if (got.max_frame_len !== want.max_frame_len)
            report_mismatch($sformatf("max_frame_len got %0d want %0d",
                                      got.max_frame_len, want.max_frame_len));
        if (got.gap_ms !== want.gap_ms)
            report_mismatch($sformatf("gap_ms got %0d want %0d", got.gap_ms, want.gap_ms));
    endtask

    task automatic offer_flow(input vlbs_pkg::t_in f, input vlbs_pkg::t_out want,
                              input bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in       <= f;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        link_q.push_back(want);
        flows_taken++;
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_link(o_out);
        if (long_hold) begin
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(1, 6) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // hold off the receiver long enough that the block backs up into its input
    initial begin
        while (flows_taken < FLOW_ROW_COUNT + 40) @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        vlbs_pkg::t_in f;
        int            i;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (i = 0; i < FLOW_ROW_COUNT; i++)
            offer_flow(FLOW_ROWS[i].flow,
                       FLOW_ROWS[i].typed ? FLOW_ROWS[i].want : size_link(FLOW_ROWS[i].flow),
                       1'b1);
        for (i = 0; i < RANDOM_FLOWS; i++) begin
            if (i == RANDOM_FLOWS - QUIET_FLOWS) quiet <= 1'b1;
            f = random_flow();
            offer_flow(f, size_link(f), i < RANDOM_FLOWS - QUIET_FLOWS);
        end
        i_in_valid <= 1'b0;
        while (link_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && link_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
